FILE: hw/rtl/gfrp_pkg.sv
// Shared types, constants and codes of the guillotine free-rectangle packer.
package gfrp_pkg;

   localparam int MAX_FREE_RECTS = 64;
   localparam int COORD_BITS     = 15;
   localparam int SPACING_BITS   = 8;
   localparam int IDX_BITS       = (MAX_FREE_RECTS > 1) ? $clog2(MAX_FREE_RECTS) : 1;
   localparam int CNT_BITS       = IDX_BITS + 1;
   localparam int SIZE_BITS      = COORD_BITS + 1;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [COORD_BITS-1:0]   RESET_ATLAS_WIDTH  = COORD_BITS'(1024);
   localparam logic [COORD_BITS-1:0]   RESET_ATLAS_HEIGHT = COORD_BITS'(1024);
   localparam logic [SPACING_BITS-1:0] RESET_SPACING      = SPACING_BITS'(2);

   localparam logic OP_PACK  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      REG_ATLAS_WIDTH  = 2'd0,
      REG_ATLAS_HEIGHT = 2'd1,
      REG_SPACING      = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_SHIFT,
      ST_SPLIT1,
      ST_SPLIT2,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] h;
   } rect_type;

   // Initial free rectangle: origin at spacing, extent saturating at zero.
   function automatic rect_type reload_rect(input logic [COORD_BITS-1:0]   width,
                                            input logic [COORD_BITS-1:0]   height,
                                            input logic [SPACING_BITS-1:0] space);
      rect_type              r;
      logic [COORD_BITS-1:0] sp;
      sp  = COORD_BITS'(space);
      r.x = sp;
      r.y = sp;
      r.w = (width > sp) ? COORD_BITS'(width - sp) : '0;
      r.h = (height > sp) ? COORD_BITS'(height - sp) : '0;
      return r;
   endfunction

endpackage

FILE: hw/rtl/gfrp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gfrp_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/guillotine_free_rect_packer.sv
// Guillotine first-fit atlas packer: free-rectangle table, sequencer and CSRs.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------------------
//   req      | in        | req_valid/stall    | operation, rect_width, rect_height
//   rsp      | out       | rsp_valid/stall    | placed, place_x/y, placed_width/height,
//            |           |                    | table_overflow
//   csr      | in/out    | APB psel/penable   | atlas_width, atlas_height, spacing
//
// A pack request scans the table for its first fit, compacts the entries behind the fit
// one slot down, appends up to two split rectangles and then finishes. A miss scans
// every entry and finishes; a pack on an empty table goes straight to finish, and a
// clear request reloads the table and finishes.
// The table RAM moves one entry per cycle through its read and write ports during compaction.
// After reset the block writes the initial free rectangle before it goes idle.
// A result waiting under rsp_stall holds in the output register; the next
// request is still taken and holds at its finish step until the slot frees.
module guillotine_free_rect_packer (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [gfrp_pkg::COORD_BITS-1:0]      req_rect_width,
   input  logic [gfrp_pkg::COORD_BITS-1:0]      req_rect_height,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_placed,
   output logic [gfrp_pkg::COORD_BITS-1:0]      rsp_place_x,
   output logic [gfrp_pkg::COORD_BITS-1:0]      rsp_place_y,
   output logic [gfrp_pkg::COORD_BITS-1:0]      rsp_placed_width,
   output logic [gfrp_pkg::COORD_BITS-1:0]      rsp_placed_height,
   output logic                                 rsp_table_overflow,
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [gfrp_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [gfrp_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [gfrp_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int CB = gfrp_pkg::COORD_BITS;
   localparam int SB = gfrp_pkg::SPACING_BITS;
   localparam int IB = gfrp_pkg::IDX_BITS;
   localparam int NB = gfrp_pkg::CNT_BITS;
   localparam int ZB = gfrp_pkg::SIZE_BITS;
   localparam int RB = $bits(gfrp_pkg::rect_type);

   // ---------------------------------------------------------------- CSRs
   logic [CB-1:0] atlas_width_ff,  atlas_width_in;
   logic [CB-1:0] atlas_height_ff, atlas_height_in;
   logic [SB-1:0] spacing_ff,      spacing_in;
   logic          csr_write;
   gfrp_pkg::reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = gfrp_pkg::reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      atlas_width_in  = atlas_width_ff;
      atlas_height_in = atlas_height_ff;
      spacing_in      = spacing_ff;
      csr_prdata      = '0;
      unique case (csr_index)
         gfrp_pkg::REG_ATLAS_WIDTH: begin
            csr_prdata = gfrp_pkg::CSR_DATA_BITS'(atlas_width_ff);
            if (csr_write) atlas_width_in = csr_pwdata[CB-1:0];
         end
         gfrp_pkg::REG_ATLAS_HEIGHT: begin
            csr_prdata = gfrp_pkg::CSR_DATA_BITS'(atlas_height_ff);
            if (csr_write) atlas_height_in = csr_pwdata[CB-1:0];
         end
         gfrp_pkg::REG_SPACING: begin
            csr_prdata = gfrp_pkg::CSR_DATA_BITS'(spacing_ff);
            if (csr_write) spacing_in = csr_pwdata[SB-1:0];
         end
         default: begin
            // unmapped address: drop the write, read zero
            csr_prdata = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------- state
   gfrp_pkg::state_type state_ff, state_in;

   logic [NB-1:0]  count_ff, count_in;       // valid entries in the free table
   logic [NB-1:0]  iss_ff, iss_in;           // next table address to read
   logic           rvld_ff, rvld_in;         // read data in flight is valid
   logic [IB-1:0]  chk_ff, chk_in;           // address of the data in flight
   logic [ZB-1:0]  tw_ff, tw_in;             // padded width
   logic [ZB-1:0]  th_ff, th_in;             // padded height
   gfrp_pkg::rect_type hit_ff, hit_in;       // entry taken by the fit
   logic [CB-1:0]  ex_ff, ex_in;
   logic [CB-1:0]  ey_ff, ey_in;

   logic           res_placed_ff, res_placed_in;
   logic [CB-1:0]  res_x_ff, res_x_in;
   logic [CB-1:0]  res_y_ff, res_y_in;
   logic [CB-1:0]  res_w_ff, res_w_in;
   logic [CB-1:0]  res_h_ff, res_h_in;
   logic           res_ovf_ff, res_ovf_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_placed_ff, rsp_placed_in;
   logic [CB-1:0]  rsp_x_ff, rsp_x_in;
   logic [CB-1:0]  rsp_y_ff, rsp_y_in;
   logic [CB-1:0]  rsp_w_ff, rsp_w_in;
   logic [CB-1:0]  rsp_h_ff, rsp_h_in;
   logic           rsp_ovf_ff, rsp_ovf_in;

   // ---------------------------------------------------------------- table RAM
   logic               ram_we;
   logic [IB-1:0]      ram_wa;
   gfrp_pkg::rect_type ram_wd;
   logic               ram_re;
   logic [IB-1:0]      ram_ra;
   logic [RB-1:0]      ram_rd_bits;
   gfrp_pkg::rect_type ram_rd;

   gfrp_ram #(
      .WIDTH     (RB),
      .DEPTH     (gfrp_pkg::MAX_FREE_RECTS),
      .ADDR_BITS (IB)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd = gfrp_pkg::rect_type'(ram_rd_bits);

   // ---------------------------------------------------------------- shared compare / split unit
   logic               req_accept;
   logic               issue;          // a table read goes out this cycle
   logic               fit;            // entry in flight holds the padded size
   logic               last_chk;       // entry in flight is the last one
   logic               room;           // a free slot is left for an append
   logic               out_free;       // output register can take a result
   logic               ex_first;
   gfrp_pkg::rect_type split_a, split_b, split_c, split_d;
   gfrp_pkg::rect_type first_rect, second_rect;
   logic               first_ok, second_ok;
   logic [CB-1:0]      twc, thc;

   assign req_stall  = (state_ff != gfrp_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign issue      = (iss_ff < count_ff);
   assign fit        = ({1'b0, ram_rd.w} >= tw_ff) && ({1'b0, ram_rd.h} >= th_ff);
   assign last_chk   = (({1'b0, chk_ff} + NB'(1)) == count_ff);
   assign room       = (count_ff < NB'(gfrp_pkg::MAX_FREE_RECTS));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // The padded size fits a 15-bit entry once a fit is found.
   assign twc = tw_ff[CB-1:0];
   assign thc = th_ff[CB-1:0];

   // Cut the larger excess first; a cut only exists for excess above zero.
   always_comb begin
      ex_first = (ex_ff > ey_ff);
      split_a  = '{x: CB'(hit_ff.x + twc), y: hit_ff.y, w: ex_ff, h: hit_ff.h};
      split_b  = '{x: hit_ff.x, y: CB'(hit_ff.y + thc), w: hit_ff.w, h: ey_ff};
      split_c  = '{x: hit_ff.x, y: CB'(hit_ff.y + thc), w: twc, h: ey_ff};
      split_d  = '{x: CB'(hit_ff.x + twc), y: hit_ff.y, w: ex_ff,
                   h: (ey_ff != '0) ? thc : hit_ff.h};
      if (ex_first) begin
         first_rect  = split_a;
         first_ok    = (ex_ff != '0);
         second_rect = split_c;
         second_ok   = (ey_ff != '0);
      end else begin
         first_rect  = split_b;
         first_ok    = (ey_ff != '0);
         second_rect = split_d;
         second_ok   = (ex_ff != '0);
      end
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gfrp_pkg::ST_INIT: state_in = gfrp_pkg::ST_IDLE;
         gfrp_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_operation == gfrp_pkg::OP_CLEAR) state_in = gfrp_pkg::ST_CLEAR;
               else if (count_ff == '0)                 state_in = gfrp_pkg::ST_FINISH;
               else                                     state_in = gfrp_pkg::ST_SCAN;
            end
         end
         gfrp_pkg::ST_CLEAR: state_in = gfrp_pkg::ST_FINISH;
         gfrp_pkg::ST_SCAN: begin
            priority if (rvld_ff && fit) state_in = gfrp_pkg::ST_SHIFT;
            else if (rvld_ff && last_chk) state_in = gfrp_pkg::ST_FINISH;
         end
         gfrp_pkg::ST_SHIFT: begin
            if (!issue && !rvld_ff) state_in = gfrp_pkg::ST_SPLIT1;
         end
         gfrp_pkg::ST_SPLIT1: state_in = gfrp_pkg::ST_SPLIT2;
         gfrp_pkg::ST_SPLIT2: state_in = gfrp_pkg::ST_FINISH;
         gfrp_pkg::ST_FINISH: begin
            if (out_free) state_in = gfrp_pkg::ST_IDLE;
         end
         default: state_in = gfrp_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- RAM control
   always_comb begin
      ram_we = 1'b0;
      ram_wa = '0;
      ram_wd = '0;
      ram_re = 1'b0;
      ram_ra = iss_ff[IB-1:0];
      unique case (state_ff)
         gfrp_pkg::ST_INIT: begin
            ram_we = 1'b1;
            ram_wd = gfrp_pkg::reload_rect(gfrp_pkg::RESET_ATLAS_WIDTH,
                                           gfrp_pkg::RESET_ATLAS_HEIGHT,
                                           gfrp_pkg::RESET_SPACING);
         end
         gfrp_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wd = gfrp_pkg::reload_rect(atlas_width_ff, atlas_height_ff, spacing_ff);
         end
         gfrp_pkg::ST_SCAN: begin
            ram_re = issue;
         end
         gfrp_pkg::ST_SHIFT: begin
            // read entry k+1 while entry k-1's successor lands one slot down
            ram_re = issue;
            ram_we = rvld_ff;
            ram_wa = IB'(chk_ff - IB'(1));
            ram_wd = ram_rd;
         end
         gfrp_pkg::ST_SPLIT1: begin
            ram_we = first_ok && room;
            ram_wa = count_ff[IB-1:0];
            ram_wd = first_rect;
         end
         gfrp_pkg::ST_SPLIT2: begin
            ram_we = second_ok && room;
            ram_wa = count_ff[IB-1:0];
            ram_wd = second_rect;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      count_in      = count_ff;
      iss_in        = iss_ff;
      rvld_in       = 1'b0;
      chk_in        = iss_ff[IB-1:0];
      tw_in         = tw_ff;
      th_in         = th_ff;
      hit_in        = hit_ff;
      ex_in         = ex_ff;
      ey_in         = ey_ff;
      res_placed_in = res_placed_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_w_in      = res_w_ff;
      res_h_in      = res_h_ff;
      res_ovf_in    = res_ovf_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_placed_in = rsp_placed_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_w_in      = rsp_w_ff;
      rsp_h_in      = rsp_h_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      unique case (state_ff)
         gfrp_pkg::ST_IDLE: begin
            if (req_accept) begin
               // pad by twice the spacing; a clear echoes nothing
               tw_in         = ZB'(req_rect_width) + ZB'({spacing_ff, 1'b0});
               th_in         = ZB'(req_rect_height) + ZB'({spacing_ff, 1'b0});
               iss_in        = '0;
               res_placed_in = 1'b0;
               res_x_in      = '0;
               res_y_in      = '0;
               res_ovf_in    = 1'b0;
               if (req_operation == gfrp_pkg::OP_CLEAR) begin
                  res_w_in = '0;
                  res_h_in = '0;
               end else begin
                  res_w_in = req_rect_width;
                  res_h_in = req_rect_height;
               end
            end
         end
         gfrp_pkg::ST_CLEAR: begin
            count_in = NB'(1);
         end
         gfrp_pkg::ST_SCAN: begin
            if (issue) iss_in = iss_ff + NB'(1);
            rvld_in = issue;
            if (rvld_ff && fit) begin
               // take this entry, then compact from the next one on
               hit_in        = ram_rd;
               ex_in         = CB'({1'b0, ram_rd.w} - tw_ff);
               ey_in         = CB'({1'b0, ram_rd.h} - th_ff);
               res_placed_in = 1'b1;
               res_x_in      = CB'(ram_rd.x + CB'(spacing_ff));
               res_y_in      = CB'(ram_rd.y + CB'(spacing_ff));
               iss_in        = {1'b0, chk_ff} + NB'(1);
               rvld_in       = 1'b0;
            end
         end
         gfrp_pkg::ST_SHIFT: begin
            if (issue) iss_in = iss_ff + NB'(1);
            rvld_in = issue;
            if (!issue && !rvld_ff) count_in = count_ff - NB'(1);
         end
         gfrp_pkg::ST_SPLIT1: begin
            if (first_ok) begin
               if (room) count_in   = count_ff + NB'(1);
               else      res_ovf_in = 1'b1;
            end
         end
         gfrp_pkg::ST_SPLIT2: begin
            if (second_ok) begin
               if (room) count_in   = count_ff + NB'(1);
               else      res_ovf_in = 1'b1;
            end
         end
         gfrp_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_placed_in = res_placed_ff;
               rsp_x_in      = res_x_ff;
               rsp_y_in      = res_y_ff;
               rsp_w_in      = res_w_ff;
               rsp_h_in      = res_h_ff;
               rsp_ovf_in    = res_ovf_ff;
            end
         end
         default: begin
            rvld_in = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= gfrp_pkg::ST_INIT;
         count_ff        <= NB'(1);
         iss_ff          <= '0;
         rvld_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         atlas_width_ff  <= gfrp_pkg::RESET_ATLAS_WIDTH;
         atlas_height_ff <= gfrp_pkg::RESET_ATLAS_HEIGHT;
         spacing_ff      <= gfrp_pkg::RESET_SPACING;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         iss_ff          <= iss_in;
         rvld_ff         <= rvld_in;
         rsp_valid_ff    <= rsp_valid_in;
         atlas_width_ff  <= atlas_width_in;
         atlas_height_ff <= atlas_height_in;
         spacing_ff      <= spacing_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff        <= chk_in;
      tw_ff         <= tw_in;
      th_ff         <= th_in;
      hit_ff        <= hit_in;
      ex_ff         <= ex_in;
      ey_ff         <= ey_in;
      res_placed_ff <= res_placed_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_w_ff      <= res_w_in;
      res_h_ff      <= res_h_in;
      res_ovf_ff    <= res_ovf_in;
      rsp_placed_ff <= rsp_placed_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_w_ff      <= rsp_w_in;
      rsp_h_ff      <= rsp_h_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_placed         = rsp_placed_ff;
   assign rsp_place_x        = rsp_x_ff;
   assign rsp_place_y        = rsp_y_ff;
   assign rsp_placed_width   = rsp_w_ff;
   assign rsp_placed_height  = rsp_h_ff;
   assign rsp_table_overflow = rsp_ovf_ff;

   // ---------------------------------------------------------------- assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NB'(gfrp_pkg::MAX_FREE_RECTS))
      else $error("free table count beyond capacity");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == gfrp_pkg::ST_FINISH))
      else $error("result raised outside the finish step");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gfrp_pkg::ST_SCAN) |-> !ram_we)
      else $error("table written during the first-fit scan");

   a_overflow_needs_place: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_placed_ff |-> !rsp_ovf_ff)
      else $error("overflow flagged on a result that placed nothing");

   a_idle_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gfrp_pkg::ST_IDLE) && $past(state_ff == gfrp_pkg::ST_IDLE)
      |-> $stable(count_ff))
      else $error("free table count moved while idle");

endmodule
